// ===== src/kli_pkg.sv =====
// Shared types, codes and helpers of the keyframe linear interpolator.
package kli_pkg;

    localparam logic [2:0] OPC_SET_POSE = 3'd0;
    localparam logic [2:0] OPC_SAVE     = 3'd1;
    localparam logic [2:0] OPC_DELETE   = 3'd2;
    localparam logic [2:0] OPC_CLEAR    = 3'd3;
    localparam logic [2:0] OPC_START    = 3'd4;
    localparam logic [2:0] OPC_TICK     = 3'd5;

    localparam logic signed [31:0] ANGLE_RESET = 32'sh00B4_0000;

    typedef enum logic [2:0] {
        OP_SET_POSE,
        OP_SAVE,
        OP_DELETE,
        OP_CLEAR,
        OP_START,
        OP_TICK,
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_FEWER  = 3'd3,
        ST_BUSY   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_EXEC,
        BS_RD_A,
        BS_RD_B,
        BS_DIV,
        BS_ADD,
        BS_SNAP,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] angle;
    } t_qitem;

    function automatic logic signed [31:0] sat_s32(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v > 34'sh0_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            res = -32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ===== src/kli_front.sv =====
// Front end: accepts requests, decodes the opcode and queues them for the back end.
module kli_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_opcode,
    input  logic signed [31:0] i_in_x,
    input  logic signed [31:0] i_in_y,
    input  logic signed [31:0] i_in_z,
    input  logic signed [31:0] i_in_angle,
    output kli_pkg::t_qitem    o_head,
    output logic               o_head_valid,
    input  logic               i_pop
);
    import kli_pkg::*;

    t_qitem     r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_op        dec_op;
    logic       push;
    logic       pop;

    always_comb begin
        unique case (i_opcode)
            OPC_SET_POSE: dec_op = OP_SET_POSE;
            OPC_SAVE:     dec_op = OP_SAVE;
            OPC_DELETE:   dec_op = OP_DELETE;
            OPC_CLEAR:    dec_op = OP_CLEAR;
            OPC_START:    dec_op = OP_START;
            OPC_TICK:     dec_op = OP_TICK;
            default:      dec_op = OP_NOP;
        endcase
    end

    assign o_stall      = (r_cnt == 2'd2);
    assign push         = i_valid && !o_stall;
    assign o_head_valid = (r_cnt != 2'd0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{op: dec_op, x: i_in_x, y: i_in_y, z: i_in_z, angle: i_in_angle};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== src/kli_div.sv =====
// Divider lane: signed dividend by a constant through a reciprocal multiply.
module kli_div #(
    parameter int DIVISOR = 90
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_dividend,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    import kli_pkg::*;

    localparam int          SHIFT    = 33 + $clog2(DIVISOR);
    localparam logic [63:0] RECIP    = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1)
                                       / 64'(DIVISOR);
    localparam logic [16:0] RECIP_LO = RECIP[16:0];
    localparam logic [16:0] RECIP_HI = RECIP[33:17];

    logic [32:0]        r_mag;
    logic               r_neg;
    logic [49:0]        r_plo;
    logic [49:0]        r_phi;
    logic [32:0]        r_qmag;
    logic               r_v1;
    logic               r_v2;
    logic               r_done;
    logic [66:0]        prod_sum;
    logic signed [33:0] signed_q;

    assign prod_sum = {r_phi, 17'd0} + 67'(r_plo);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[32];
            r_mag <= i_dividend[32] ? 33'(-i_dividend) : 33'(i_dividend);
        end
        if (r_v1) begin
            r_plo <= r_mag * RECIP_LO;
            r_phi <= r_mag * RECIP_HI;
        end
        if (r_v2) begin
            r_qmag <= 33'(prod_sum >> SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
    end

    assign signed_q = r_neg ? -$signed({1'b0, r_qmag}) : $signed({1'b0, r_qmag});
    assign o_quot   = sat_s32(signed_q);
    assign o_done   = r_done;

endmodule

// ===== src/kli_back.sv =====
// Back end: keyframe table, pose registers, playback sequencer and result register.
module kli_back #(
    parameter int MAX_KEYFRAMES     = 128,
    parameter int STEPS_PER_SEGMENT = 90
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kli_pkg::t_qitem    i_head,
    input  logic               i_head_valid,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pose_x,
    output logic signed [31:0] o_pose_y,
    output logic signed [31:0] o_pose_z,
    output logic signed [31:0] o_pose_angle,
    output logic               o_playing,
    output logic               o_finished,
    output logic [7:0]         o_frames_stored,
    output logic [2:0]         o_status
);
    import kli_pkg::*;

    localparam int AW = $clog2(MAX_KEYFRAMES);
    localparam int CW = $clog2(MAX_KEYFRAMES + 1);
    localparam int SW = $clog2(STEPS_PER_SEGMENT + 1);

    t_bstate            r_state;
    t_bstate            n_state;
    t_qitem             r_item;
    logic [127:0]       r_mem [MAX_KEYFRAMES];
    logic [127:0]       r_rd_data;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic               div_start;
    logic [3:0]         div_done;
    logic signed [31:0] quot [4];
    logic signed [32:0] dividend [4];
    logic signed [31:0] r_pose [4];
    logic signed [31:0] r_inc [4];
    logic signed [31:0] r_fa [4];
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_seg;
    logic [SW-1:0]      r_step;
    logic               r_running;
    t_status            r_status;
    logic               r_fin;
    logic               r_ovalid;
    logic               out_free;
    logic [AW-1:0]      seg_next;
    logic               seg_end;
    logic               wrap;
    logic               has_two;
    logic               not_full;
    logic [CW-1:0]      last_idx;

    assign out_free = !r_ovalid || !i_stall;
    assign seg_next = r_seg + 1'b1;
    assign seg_end  = (r_step >= SW'(STEPS_PER_SEGMENT));
    assign wrap     = ((CW+1)'(seg_next) + (CW+1)'(2)) > (CW+1)'(r_count);
    assign has_two  = (r_count >= CW'(2));
    assign not_full = (r_count < CW'(MAX_KEYFRAMES));
    assign last_idx = r_count - 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (i_head_valid) begin
                    n_state = BS_EXEC;
                end
            end
            BS_EXEC: begin
                case (r_item.op)
                    OP_START: n_state = has_two ? BS_RD_A : BS_DONE;
                    OP_TICK: begin
                        if (!r_running) begin
                            n_state = BS_DONE;
                        end else if (!seg_end) begin
                            n_state = BS_ADD;
                        end else begin
                            n_state = wrap ? BS_SNAP : BS_RD_A;
                        end
                    end
                    default: n_state = BS_DONE;
                endcase
            end
            BS_RD_A: n_state = BS_RD_B;
            BS_RD_B: n_state = BS_DIV;
            BS_DIV: begin
                if (div_done[0]) begin
                    n_state = (r_item.op == OP_TICK) ? BS_ADD : BS_DONE;
                end
            end
            BS_ADD:  n_state = BS_DONE;
            BS_SNAP: n_state = BS_DONE;
            BS_DONE: begin
                if (out_free) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = (r_state == BS_IDLE) && i_head_valid;
        wr_en     = (r_state == BS_EXEC) && (r_item.op == OP_SAVE) && !r_running && not_full;
        div_start = (r_state == BS_RD_B);
        rd_addr   = '0;
        if (r_state == BS_EXEC && r_item.op == OP_TICK) begin
            rd_addr = wrap ? last_idx[AW-1:0] : seg_next;
        end else if (r_state == BS_RD_A) begin
            rd_addr = seg_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= {r_pose[3], r_pose[2], r_pose[1], r_pose[0]};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        assign dividend[k] = 33'($signed(r_rd_data[k*32 +: 32])) - 33'(r_fa[k]);
        kli_div #(
            .DIVISOR(STEPS_PER_SEGMENT)
        ) u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (div_start),
            .i_dividend (dividend[k]),
            .o_done     (div_done[k]),
            .o_quot     (quot[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
        if (r_state == BS_RD_A) begin
            for (int k = 0; k < 4; k++) begin
                r_fa[k] <= r_rd_data[k*32 +: 32];
            end
        end
        if (r_state == BS_DONE && out_free) begin
            o_pose_x        <= r_pose[0];
            o_pose_y        <= r_pose[1];
            o_pose_z        <= r_pose[2];
            o_pose_angle    <= r_pose[3];
            o_playing       <= r_running;
            o_finished      <= r_fin;
            o_frames_stored <= 8'(r_count);
            o_status        <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_pose[0] <= '0;
            r_pose[1] <= '0;
            r_pose[2] <= '0;
            r_pose[3] <= ANGLE_RESET;
            for (int k = 0; k < 4; k++) begin
                r_inc[k] <= '0;
            end
            r_count   <= '0;
            r_seg     <= '0;
            r_step    <= '0;
            r_running <= 1'b0;
            r_status  <= ST_OK;
            r_fin     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                BS_IDLE: begin
                    r_status <= ST_OK;
                    r_fin    <= 1'b0;
                end
                BS_EXEC: begin
                    case (r_item.op)
                        OP_SET_POSE: begin
                            if (r_running) begin
                                r_status <= ST_BUSY;
                            end else begin
                                r_pose[0] <= r_item.x;
                                r_pose[1] <= r_item.y;
                                r_pose[2] <= r_item.z;
                                r_pose[3] <= r_item.angle;
                            end
                        end
                        OP_SAVE: begin
                            if (r_running) begin
                                r_status <= ST_BUSY;
                            end else if (!not_full) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            if (r_running) begin
                                r_status <= ST_BUSY;
                            end else if (r_count == '0) begin
                                r_status <= ST_EMPTY;
                            end else begin
                                r_count <= last_idx;
                            end
                        end
                        OP_CLEAR: begin
                            r_pose[0] <= '0;
                            r_pose[1] <= '0;
                            r_pose[2] <= '0;
                            r_pose[3] <= ANGLE_RESET;
                            r_count   <= '0;
                            r_seg     <= '0;
                            r_step    <= '0;
                            r_running <= 1'b0;
                        end
                        OP_START: begin
                            if (!has_two) begin
                                r_status <= ST_FEWER;
                            end else begin
                                r_running <= 1'b1;
                                r_seg     <= '0;
                                r_step    <= '0;
                            end
                        end
                        OP_TICK: begin
                            if (r_running && seg_end) begin
                                r_seg <= seg_next;
                                if (!wrap) begin
                                    r_step <= '0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                BS_RD_A: begin
                    if (r_item.op == OP_START) begin
                        for (int k = 0; k < 4; k++) begin
                            r_pose[k] <= r_rd_data[k*32 +: 32];
                        end
                    end
                end
                BS_DIV: begin
                    if (div_done[0]) begin
                        for (int k = 0; k < 4; k++) begin
                            r_inc[k] <= quot[k];
                        end
                    end
                end
                BS_ADD: begin
                    for (int k = 0; k < 4; k++) begin
                        r_pose[k] <= sat_s32(34'(r_pose[k]) + 34'(r_inc[k]));
                    end
                    r_step <= r_step + 1'b1;
                end
                BS_SNAP: begin
                    for (int k = 0; k < 4; k++) begin
                        r_pose[k] <= r_rd_data[k*32 +: 32];
                    end
                    r_running <= 1'b0;
                    r_seg     <= '0;
                    r_step    <= '0;
                    r_fin     <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid = r_ovalid;

endmodule

// ===== src/keyframe_linear_interpolator_unit.sv =====
// Top level of the keyframe linear interpolator: request queue, sequencer and result register.
// Table and pose commands pass the exec and done states; a tick inside a segment adds the
// add state and the snap the snap state. A start and a tick that enters a new segment both
// read two table entries and run the reciprocal-multiply divider lanes; the tick then adds.
// The sequencer finishes one request before it takes the next; a two-entry queue absorbs input.
// Synchronous active-low reset clears pose to angle 180, the table count and playback.
module keyframe_linear_interpolator_unit #(
    parameter int MAX_KEYFRAMES     = 128,
    parameter int STEPS_PER_SEGMENT = 90
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_opcode,
    input  logic signed [31:0] i_in_x,
    input  logic signed [31:0] i_in_y,
    input  logic signed [31:0] i_in_z,
    input  logic signed [31:0] i_in_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pose_x,
    output logic signed [31:0] o_pose_y,
    output logic signed [31:0] o_pose_z,
    output logic signed [31:0] o_pose_angle,
    output logic               o_playing,
    output logic               o_finished,
    output logic [7:0]         o_frames_stored,
    output logic [2:0]         o_status
);
    import kli_pkg::*;

    t_qitem head;
    logic   head_valid;
    logic   pop;

    kli_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_in_x       (i_in_x),
        .i_in_y       (i_in_y),
        .i_in_z       (i_in_z),
        .i_in_angle   (i_in_angle),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    kli_back #(
        .MAX_KEYFRAMES     (MAX_KEYFRAMES),
        .STEPS_PER_SEGMENT (STEPS_PER_SEGMENT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_head_valid    (head_valid),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pose_x        (o_pose_x),
        .o_pose_y        (o_pose_y),
        .o_pose_z        (o_pose_z),
        .o_pose_angle    (o_pose_angle),
        .o_playing       (o_playing),
        .o_finished      (o_finished),
        .o_frames_stored (o_frames_stored),
        .o_status        (o_status)
    );

endmodule

// ===== src/kli_checker.sv =====
// Port-level checker for the keyframe linear interpolator and its bind.
module kli_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_pose_x,
    input logic               o_playing,
    input logic               o_finished,
    input logic [7:0]         o_frames_stored,
    input logic [2:0]         o_status
);
    import kli_pkg::*;

    a_busy_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_BUSY) |-> o_playing)
        else $error("busy status reported while not playing");

    a_finish_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_finished |-> !o_playing && (o_status == ST_OK))
        else $error("finished result still playing or not ok");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_status == ST_EMPTY) || (o_status == ST_FEWER))
        |-> (o_frames_stored < 8'd2) && ((o_status != ST_EMPTY) || (o_frames_stored == 8'd0)))
        else $error("table status disagrees with frame count");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pose_x) && $stable(o_status))
        else $error("stalled result changed");

endmodule

bind keyframe_linear_interpolator_unit kli_checker u_kli_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_pose_x        (o_pose_x),
    .o_playing       (o_playing),
    .o_finished      (o_finished),
    .o_frames_stored (o_frames_stored),
    .o_status        (o_status)
);

// ===== bench/keyframe_pose_checker.sv =====
// Request and pose report monitor with an in-line keyframe predictor and scoreboard.
module keyframe_pose_checker #(
    parameter int TABLE_DEPTH = 128,
    parameter int STEPS       = 90
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_stall,
    input  logic [2:0]         i_opcode,
    input  logic signed [31:0] i_in_x,
    input  logic signed [31:0] i_in_y,
    input  logic signed [31:0] i_in_z,
    input  logic signed [31:0] i_in_angle,
    input  logic               i_rsp_valid,
    input  logic               i_rsp_stall,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic signed [31:0] i_pose_z,
    input  logic signed [31:0] i_pose_angle,
    input  logic               i_playing,
    input  logic               i_finished,
    input  logic [7:0]         i_frames_stored,
    input  logic [2:0]         i_status,
    output int                 o_mismatches,
    output int                 o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import kli_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] angle;
        logic               playing;
        logic               finished;
        logic [7:0]         frames;
        logic [2:0]         status;
    } t_pose_report;

    logic signed [31:0] keyframes [TABLE_DEPTH][4];
    logic signed [31:0] pose [4];
    logic signed [31:0] step_delta [4];
    int unsigned        frame_total;
    int unsigned        seg_index;
    int unsigned        step_count;
    bit                 playing_now;
    t_pose_report       expected_poses [$];
    int                 fault_count = 0;

    assign o_mismatches = fault_count;

    function automatic logic signed [31:0] clamp_s32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic void derive_increment();
        longint span;
        for (int k = 0; k < 4; k++) begin
            span = longint'(keyframes[seg_index + 1][k]) - longint'(keyframes[seg_index][k]);
            step_delta[k] = clamp_s32(span / longint'(STEPS));
        end
    endfunction

    function automatic t_pose_report apply_request(input logic [2:0] op,
                                                   input logic signed [31:0] x,
                                                   input logic signed [31:0] y,
                                                   input logic signed [31:0] z,
                                                   input logic signed [31:0] a);
        t_status      verdict;
        bit           done;
        t_pose_report rep;
        verdict = ST_OK;
        done    = 1'b0;
        case (op)
            OPC_SET_POSE: begin
                if (playing_now) begin
                    verdict = ST_BUSY;
                end else begin
                    pose[0] = x;
                    pose[1] = y;
                    pose[2] = z;
                    pose[3] = a;
                end
            end
            OPC_SAVE: begin
                if (playing_now) begin
                    verdict = ST_BUSY;
                end else if (frame_total >= TABLE_DEPTH) begin
                    verdict = ST_FULL;
                end else begin
                    for (int k = 0; k < 4; k++) keyframes[frame_total][k] = pose[k];
                    frame_total++;
                end
            end
            OPC_DELETE: begin
                if (playing_now) begin
                    verdict = ST_BUSY;
                end else if (frame_total == 0) begin
                    verdict = ST_EMPTY;
                end else begin
                    frame_total--;
                end
            end
            OPC_CLEAR: begin
                pose[0] = '0;
                pose[1] = '0;
                pose[2] = '0;
                pose[3] = ANGLE_RESET;
                frame_total = 0;
                seg_index   = 0;
                step_count  = 0;
                playing_now = 1'b0;
            end
            OPC_START: begin
                if (frame_total < 2) begin
                    verdict = ST_FEWER;
                end else begin
                    playing_now = 1'b1;
                    seg_index   = 0;
                    step_count  = 0;
                    for (int k = 0; k < 4; k++) pose[k] = keyframes[0][k];
                    derive_increment();
                end
            end
            OPC_TICK: begin
                if (playing_now) begin
                    if (step_count >= STEPS) begin
                        seg_index++;
                        if (seg_index + 2 > frame_total) begin
                            for (int k = 0; k < 4; k++) pose[k] = keyframes[frame_total - 1][k];
                            playing_now = 1'b0;
                            seg_index   = 0;
                            step_count  = 0;
                            done        = 1'b1;
                        end else begin
                            step_count = 0;
                            derive_increment();
                        end
                    end
                    if (!done) begin
                        for (int k = 0; k < 4; k++) begin
                            pose[k] = clamp_s32(longint'(pose[k]) + longint'(step_delta[k]));
                        end
                        step_count++;
                    end
                end
            end
            default: begin
            end
        endcase
        rep.x        = pose[0];
        rep.y        = pose[1];
        rep.z        = pose[2];
        rep.angle    = pose[3];
        rep.playing  = playing_now;
        rep.finished = done;
        rep.frames   = frame_total[7:0];
        rep.status   = verdict;
        return rep;
    endfunction

    always @(posedge i_clk) begin : track
        t_pose_report seen;
        t_pose_report want;
        if (!i_rst_n) begin
            pose[0] = '0;
            pose[1] = '0;
            pose[2] = '0;
            pose[3] = ANGLE_RESET;
            for (int k = 0; k < 4; k++) step_delta[k] = '0;
            frame_total = 0;
            seg_index   = 0;
            step_count  = 0;
            playing_now = 1'b0;
            expected_poses.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                seen.x        = i_pose_x;
                seen.y        = i_pose_y;
                seen.z        = i_pose_z;
                seen.angle    = i_pose_angle;
                seen.playing  = i_playing;
                seen.finished = i_finished;
                seen.frames   = i_frames_stored;
                seen.status   = i_status;
                if (expected_poses.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("unexpected pose report at %0t: x=%h y=%h z=%h a=%h",
                                 $realtime, seen.x, seen.y, seen.z, seen.angle);
                    end
                end else begin
                    want = expected_poses.pop_front();
                    if (seen.x !== want.x || seen.y !== want.y || seen.z !== want.z ||
                        seen.angle !== want.angle || seen.playing !== want.playing ||
                        seen.finished !== want.finished || seen.frames !== want.frames ||
                        seen.status !== want.status) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display("pose mismatch at %0t", $realtime);
                            $display("  exp x=%h y=%h z=%h a=%h play=%b fin=%b n=%0d st=%0d",
                                     want.x, want.y, want.z, want.angle, want.playing,
                                     want.finished, want.frames, want.status);
                            $display("  got x=%h y=%h z=%h a=%h play=%b fin=%b n=%0d st=%0d",
                                     seen.x, seen.y, seen.z, seen.angle, seen.playing,
                                     seen.finished, seen.frames, seen.status);
                        end
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                expected_poses.insert(expected_poses.size(),
                                      apply_request(i_opcode, i_in_x, i_in_y,
                                                    i_in_z, i_in_angle));
            end
        end
        o_outstanding <= expected_poses.size();
    end

endmodule

// ===== bench/keyframe_linear_interpolator_unit_tb.sv =====
// Top of the keyframe interpolator bench: clock, reset, request stimulus, stalls and verdict.
module keyframe_linear_interpolator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kli_pkg::*;

    localparam int TABLE_DEPTH = 128;
    localparam int STEPS       = 90;
    localparam int ITEM_TARGET = 800;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 60;
    localparam logic [2:0] OPC_SPARE6 = 3'd6;
    localparam logic [2:0] OPC_SPARE7 = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic [2:0]         opcode;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_angle;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_z;
    logic signed [31:0] pose_angle;
    logic               playing;
    logic               finished;
    logic [7:0]         frames_stored;
    logic [2:0]         status;
    int                 mismatches;
    int                 outstanding;
    int                 sent_count = 0;
    int                 sender_idle_pct = 0;
    int                 receiver_stall_pct = 0;
    int                 quiet_cycles = 0;

    always #6 clk = ~clk;

    keyframe_linear_interpolator_unit #(
        .MAX_KEYFRAMES     (TABLE_DEPTH),
        .STEPS_PER_SEGMENT (STEPS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (req_valid),
        .o_stall         (req_stall),
        .i_opcode        (opcode),
        .i_in_x          (in_x),
        .i_in_y          (in_y),
        .i_in_z          (in_z),
        .i_in_angle      (in_angle),
        .o_valid         (rsp_valid),
        .i_stall         (rsp_stall),
        .o_pose_x        (pose_x),
        .o_pose_y        (pose_y),
        .o_pose_z        (pose_z),
        .o_pose_angle    (pose_angle),
        .o_playing       (playing),
        .o_finished      (finished),
        .o_frames_stored (frames_stored),
        .o_status        (status)
    );

    keyframe_pose_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .STEPS       (STEPS)
    ) checker_inst (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_valid),
        .i_req_stall     (req_stall),
        .i_opcode        (opcode),
        .i_in_x          (in_x),
        .i_in_y          (in_y),
        .i_in_z          (in_z),
        .i_in_angle      (in_angle),
        .i_rsp_valid     (rsp_valid),
        .i_rsp_stall     (rsp_stall),
        .i_pose_x        (pose_x),
        .i_pose_y        (pose_y),
        .i_pose_z        (pose_z),
        .i_pose_angle    (pose_angle),
        .i_playing       (playing),
        .i_finished      (finished),
        .i_frames_stored (frames_stored),
        .i_status        (status),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    always @(negedge clk) begin
        rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [31:0] x,
                                input logic [31:0] y, input logic [31:0] z,
                                input logic [31:0] a);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        opcode    = op;
        in_x      = x;
        in_y      = y;
        in_z      = z;
        in_angle  = a;
        do @(posedge clk); while (req_stall);
        sent_count++;
        case ((sent_count / 100) % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
            default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
        endcase
    endtask

    task automatic send_op(input logic [2:0] op);
        send_request(op, $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    task automatic send_pose();
        send_request(OPC_SET_POSE, pick_coord(), pick_coord(), pick_coord(), pick_coord());
    endtask

    task automatic fill_table();
        send_op(OPC_CLEAR);
        for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
            if (i % 8 == 0) send_pose();
            send_op(OPC_SAVE);
        end
        send_op(OPC_DELETE);
        send_op(OPC_SAVE);
        send_op(OPC_SAVE);
        send_op(OPC_START);
        repeat (4) send_op(OPC_TICK);
        send_op(OPC_CLEAR);
    endtask

    task automatic play_sequence();
        int frames;
        int ticks;
        frames = ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(2, 3);
        send_op(OPC_CLEAR);
        for (int i = 0; i < frames; i++) begin
            if ($urandom_range(0, 5) != 0) send_pose();
            if ($urandom_range(0, 9) == 0) begin
                send_op(OPC_SAVE);
                send_op(OPC_DELETE);
            end
            send_op(OPC_SAVE);
        end
        send_op(OPC_START);
        ticks = STEPS * (frames - 1) + 1 + $urandom_range(0, 3);
        for (int t = 0; t < ticks; t++) begin
            if ($urandom_range(0, 29) == 0) begin
                case ($urandom_range(0, 4))
                    0:       send_pose();
                    1:       send_op(OPC_SAVE);
                    2:       send_op(OPC_DELETE);
                    3:       send_op(OPC_SPARE6);
                    default: send_op(OPC_SPARE7);
                endcase
            end else if ($urandom_range(0, 299) == 0) begin
                send_op(($urandom_range(0, 1) == 0) ? OPC_START : OPC_CLEAR);
            end
            send_op(OPC_TICK);
        end
    endtask

    task automatic random_burst();
        repeat ($urandom_range(4, 12)) begin
            send_request(3'($urandom_range(0, 7)), pick_coord(), pick_coord(),
                         pick_coord(), pick_coord());
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        opcode    = OPC_TICK;
        in_x      = '0;
        in_y      = '0;
        in_z      = '0;
        in_angle  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_op(OPC_TICK);
        send_op(OPC_DELETE);
        send_op(OPC_START);
        send_op(OPC_SPARE6);
        send_op(OPC_SPARE7);
        send_request(OPC_SET_POSE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_op(OPC_SAVE);
        send_op(OPC_START);
        send_request(OPC_SET_POSE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_op(OPC_SAVE);
        send_request(OPC_SET_POSE, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
        send_op(OPC_SAVE);
        send_op(OPC_START);
        send_pose();
        send_op(OPC_SAVE);
        send_op(OPC_DELETE);
        repeat (3) send_op(OPC_TICK);
        send_op(OPC_START);
        send_op(OPC_TICK);
        send_op(OPC_CLEAR);
        send_op(OPC_TICK);
        send_op(OPC_DELETE);

        fill_table();
        while (sent_count < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 6) begin
                play_sequence();
            end else begin
                random_burst();
            end
        end

        @(negedge clk);
        req_valid = 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
